// File: sv/scaled_segment_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Scaled segment rasterizer assertion macros
// Shorthand for clocked, reset-qualified checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SCALED_SEGMENT_RASTERIZER_ASSERT_SVH
`define SCALED_SEGMENT_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define SSR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ssr_pkg.sv
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared widths, codes, types and helper functions of the segment rasterizer.
// ----------------------------------------------------------------------------
package ssr_pkg;

	localparam int GRID_BITS   = 8;
	localparam int SCREEN_BITS = 17;
	localparam int OUT_W       = 17;
	localparam int STEP_W      = 8;
	localparam int ORG_W       = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;
	localparam int Q_DEPTH     = 2;
	localparam int QP_W        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W        = $clog2(Q_DEPTH + 1);
	localparam int SCALE_W     = GRID_BITS + STEP_W + 1;
	localparam int DIVC_W      = $clog2(SCREEN_BITS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_STEP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_XORG = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_YORG = CFG_IDX_W'(2);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef logic [SCREEN_BITS-1:0] coord_t;

	typedef struct packed {
		logic   cmd;
		coord_t ax;
		coord_t ay;
		coord_t bx;
		coord_t by;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// grid * step + origin, wrapped to the screen width
	function automatic coord_t scale_pt(
		input logic [GRID_BITS-1:0] g,
		input logic [STEP_W-1:0]    step,
		input logic [ORG_W-1:0]     org
	);
		logic [SCALE_W-1:0]             p;
		logic [SCALE_W+SCREEN_BITS-1:0] t;
		p = SCALE_W'(g) * SCALE_W'(step) + SCALE_W'(org);
		t = {{SCREEN_BITS{1'b0}}, p};
		return t[SCREEN_BITS-1:0];
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input coord_t v);
		logic [OUT_W+SCREEN_BITS-1:0] t;
		t = {{OUT_W{1'b0}}, v};
		return t[OUT_W-1:0];
	endfunction

endpackage

// File: sv/scaled_segment_rasterizer.sv
// ----------------------------------------------------------------------------
// scaled_segment_rasterizer
// Scales a grid segment to the screen and emits its interpolated pixels.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd 0 is a start word carrying two grid
// endpoints, scaled by step_size and offset by the origins on acceptance;
// cmd 1 is a tick that asks for the next pixel. A tick while no segment is
// being walked is dropped without a result. A start word aborts any segment.
// Output channel (out_valid/out_ready): one pixel per live tick, x pass first
// then y pass, last_pixel set on the final pixel of the segment.
// Config channel (cfg_valid/cfg_ready): index 0 step_size, 1 x_origin,
// 2 y_origin; always ready, write only while the block is idle.
// Flow: a two-entry queue sits behind the input. A tick passes through the pixel
// engine in order: issue, multiply, 17 divide steps of the bit-serial divider,
// write-back. A start word is taken in the issue state alone and does not enter
// the multiply or divide. The engine takes no new word until the pixel of the
// last tick is written back.
// A stalled receiver holds the pixel in the output register; the engine waits
// in write-back and the queue fills, then in_ready drops.
// Reset: step_size 1, origins 0, queue empty, no segment, out_valid low.
// ----------------------------------------------------------------------------
module scaled_segment_rasterizer import ssr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [GRID_BITS-1:0]  from_x,
	input  logic [GRID_BITS-1:0]  from_y,
	input  logic [GRID_BITS-1:0]  to_x,
	input  logic [GRID_BITS-1:0]  to_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_W-1:0]      pixel_x,
	output logic [OUT_W-1:0]      pixel_y,
	output logic                  last_pixel,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	q_stat_t q_stat;
	logic    q_push, q_pop;
	item_t   wr_item, rd_item;

	ssr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_item    (wr_item)
	);

	ssr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (wr_item),
		.pop     (q_pop),
		.rd_item (rd_item),
		.stat    (q_stat)
	);

	ssr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_item     (rd_item),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

endmodule

// File: sv/ssr_front.sv
// ----------------------------------------------------------------------------
// ssr_front
// Accepts input words, holds the scale registers and scales start endpoints.
// ----------------------------------------------------------------------------
module ssr_front import ssr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [GRID_BITS-1:0]  from_x,
	input  logic [GRID_BITS-1:0]  from_y,
	input  logic [GRID_BITS-1:0]  to_x,
	input  logic [GRID_BITS-1:0]  to_y,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  q_stat_t               q_stat,
	output logic                  q_push,
	output item_t                 q_item
);

	logic [STEP_W-1:0] step_q;
	logic [ORG_W-1:0]  xorg_q;
	logic [ORG_W-1:0]  yorg_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_stat.full;
	assign q_push    = in_valid && in_ready;

	always_comb begin
		q_item.cmd = cmd;
		q_item.ax  = scale_pt(from_x, step_q, xorg_q);
		q_item.ay  = scale_pt(from_y, step_q, yorg_q);
		q_item.bx  = scale_pt(to_x, step_q, xorg_q);
		q_item.by  = scale_pt(to_y, step_q, yorg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_W'(1);
			xorg_q <= '0;
			yorg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP: step_q <= cfg_data[STEP_W-1:0];
				REG_XORG: xorg_q <= cfg_data[ORG_W-1:0];
				REG_YORG: yorg_q <= cfg_data[ORG_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: sv/ssr_queue.sv
// ----------------------------------------------------------------------------
// ssr_queue
// Short register queue that decouples the front from the pixel engine.
// ----------------------------------------------------------------------------
module ssr_queue import ssr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   wr_item,
	input  logic    pop,
	output item_t   rd_item,
	output q_stat_t stat
);

	item_t            mem_q [Q_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  cnt_q;

	function automatic logic [QP_W-1:0] next_ptr(input logic [QP_W-1:0] p);
		return (p == QP_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rd_item    = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QC_W'(Q_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/ssr_back.sv
// ----------------------------------------------------------------------------
// ssr_back
// Pixel engine: walks the x pass then the y pass, interpolating the other
// coordinate with one multiply and a bit-serial restoring divide.
// ----------------------------------------------------------------------------
module ssr_back import ssr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  item_t            q_item,
	input  q_stat_t          q_stat,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OUT_W-1:0] pixel_x,
	output logic [OUT_W-1:0] pixel_y,
	output logic             last_pixel
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_XPASS = 2'd1;
	localparam logic [1:0] PH_YPASS = 2'd2;

	localparam logic [1:0] S_WAIT = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	localparam int PW = 2 * SCREEN_BITS;

	coord_t            ax_q, ay_q, bx_q, by_q, walk_q;
	logic [1:0]        phase_q;
	logic [1:0]        st_q;
	logic              neg_q;
	coord_t            rem_q, quo_q, span_q;
	logic [DIVC_W-1:0] cnt_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] pixel_x_q, pixel_y_q;
	logic             last_q;

	logic               ypass, live, a_lt;
	coord_t             a_m, a_o, b_m, b_o, lo_m, lo_o, hi_m;
	coord_t             hi_o, d_m, mag_o;
	logic [SCREEN_BITS:0] d_o;
	logic [PW-1:0]      prod;
	logic [SCREEN_BITS:0] trial, diff;
	logic               ge;
	coord_t             other, walk_n, px, py;
	logic               pass_end, out_free, load_out;
	logic [1:0]         phase_n;
	coord_t             walk_nx;

	assign ypass = (phase_q == PH_YPASS);
	assign live  = (phase_q == PH_XPASS) || (phase_q == PH_YPASS);

	// walked (m) and interpolated (o) coordinates of both endpoints
	always_comb begin
		a_m  = ypass ? ay_q : ax_q;
		a_o  = ypass ? ax_q : ay_q;
		b_m  = ypass ? by_q : bx_q;
		b_o  = ypass ? bx_q : by_q;
		a_lt = (a_m < b_m);
		lo_m = a_lt ? a_m : b_m;
		lo_o = a_lt ? a_o : b_o;
		hi_m = a_lt ? b_m : a_m;
		hi_o = a_lt ? b_o : a_o;
	end

	always_comb begin
		d_m   = walk_q - lo_m;
		d_o   = {1'b0, hi_o} - {1'b0, lo_o};
		mag_o = d_o[SCREEN_BITS] ? coord_t'(-d_o) : d_o[SCREEN_BITS-1:0];
		prod  = PW'(d_m) * PW'(mag_o);
	end

	// one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[SCREEN_BITS-1]};
		diff  = trial - {1'b0, span_q};
		ge    = (trial >= {1'b0, span_q});
	end

	always_comb begin
		other    = neg_q ? (lo_o - quo_q) : (lo_o + quo_q);
		px       = ypass ? other : walk_q;
		py       = ypass ? walk_q : other;
		walk_n   = walk_q + 1'b1;
		pass_end = (walk_n >= hi_m);
		phase_n  = phase_q;
		walk_nx  = walk_n;
		if (pass_end) begin
			if (ypass || (ay_q == by_q)) begin
				phase_n = PH_IDLE;
			end else begin
				phase_n = PH_YPASS;
				walk_nx = (ay_q < by_q) ? ay_q : by_q;
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign load_out = (st_q == S_OUT) && out_free;
	assign q_pop    = (st_q == S_WAIT) && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q    <= '0;
			ay_q    <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			walk_q  <= '0;
			phase_q <= PH_IDLE;
			st_q    <= S_WAIT;
			cnt_q   <= '0;
		end else begin
			unique case (st_q)
				S_WAIT: begin
					if (q_pop) begin
						if (q_item.cmd == CMD_START) begin
							ax_q <= q_item.ax;
							ay_q <= q_item.ay;
							bx_q <= q_item.bx;
							by_q <= q_item.by;
							if (q_item.ax != q_item.bx) begin
								phase_q <= PH_XPASS;
								walk_q  <= (q_item.ax < q_item.bx) ? q_item.ax : q_item.bx;
							end else if (q_item.ay != q_item.by) begin
								phase_q <= PH_YPASS;
								walk_q  <= (q_item.ay < q_item.by) ? q_item.ay : q_item.by;
							end else begin
								phase_q <= PH_IDLE;
							end
						end else if (live) begin
							st_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					cnt_q <= '0;
					st_q  <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIVC_W'(SCREEN_BITS - 1)) begin
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						phase_q <= phase_n;
						walk_q  <= walk_nx;
						st_q    <= S_WAIT;
					end
				end
				default: st_q <= S_WAIT;
			endcase
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (st_q == S_MUL) begin
			rem_q  <= prod[PW-1:SCREEN_BITS];
			quo_q  <= prod[SCREEN_BITS-1:0];
			span_q <= hi_m - lo_m;
			neg_q  <= d_o[SCREEN_BITS];
		end else if (st_q == S_DIV) begin
			rem_q <= ge ? diff[SCREEN_BITS-1:0] : trial[SCREEN_BITS-1:0];
			quo_q <= {quo_q[SCREEN_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pixel_x_q <= to_out(px);
			pixel_y_q <= to_out(py);
			last_q    <= (phase_n == PH_IDLE);
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_q;

endmodule

// File: sv/ssr_checker.sv
// ----------------------------------------------------------------------------
// ssr_checker
// Port-level checks of the segment rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "scaled_segment_rasterizer_assert.svh"

module ssr_checker import ssr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  cmd,
	input logic [GRID_BITS-1:0]  from_x,
	input logic [GRID_BITS-1:0]  from_y,
	input logic [GRID_BITS-1:0]  to_x,
	input logic [GRID_BITS-1:0]  to_y,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [OUT_W-1:0]      pixel_x,
	input logic [OUT_W-1:0]      pixel_y,
	input logic                  last_pixel,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// hold a stalled pixel word
	`SSR_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready), (out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last_pixel)), "stalled pixel word changed")

	// the engine cannot produce a third word right after two back-to-back takes
	`SSR_ASSERT_NEXT(a_out_gap, (out_valid && out_ready) ##1 (out_valid && out_ready), (!out_valid), "pixel words arrived faster than the divider allows")

	// config is taken in any cycle
	`SSR_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready, "config port not ready")

endmodule

bind scaled_segment_rasterizer ssr_checker u_ssr_checker (.*);

// File: test/scaled_segment_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_segment_rasterizer_tb
// Self-checking bench: drives start and tick words through the input channel,
// walks its own copy of the segment to predict every pixel, and compares each
// pixel taken from the output channel across a series of scale and origin
// settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module scaled_segment_rasterizer_tb;
	import ssr_pkg::*;

	localparam int RX_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES  = 40;
	localparam int TIMEOUT_NS     = 10_000_000;

	typedef enum logic [1:0] {WALK_IDLE, WALK_X, WALK_Y} walk_phase_e;

	typedef struct packed {
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic             last;
	} pixel_t;

	class pixel_scoreboard;
		logic [STEP_W-1:0] step;
		logic [ORG_W-1:0]  org_x;
		logic [ORG_W-1:0]  org_y;
		longint            ax, ay, bx, by, walk;
		walk_phase_e       phase;
		pixel_t            expected_pixels[$];
		int                errors, pixels_seen, last_seen, starts, ticks, idle_ticks;

		function new();
			step = 1;
			org_x = '0;
			org_y = '0;
			ax = 0;
			ay = 0;
			bx = 0;
			by = 0;
			walk = 0;
			phase = WALK_IDLE;
			errors = 0;
			pixels_seen = 0;
			last_seen = 0;
			starts = 0;
			ticks = 0;
			idle_ticks = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_STEP: step = data[STEP_W-1:0];
			REG_XORG: org_x = data[ORG_W-1:0];
			REG_YORG: org_y = data[ORG_W-1:0];
			default: ;
			endcase
		endfunction

		// grid * step + origin, wrapped to the screen width
		function longint scaled(input logic [GRID_BITS-1:0] g, input logic [ORG_W-1:0] org);
			longint mask;
			mask = (longint'(1) << SCREEN_BITS) - 1;
			return (longint'(g) * longint'(step) + longint'(org)) & mask;
		endfunction

		function void enter_y_walk();
			if (ay == by) begin
				phase = WALK_IDLE;
			end else begin
				walk = (ay < by) ? ay : by;
				phase = WALK_Y;
			end
		endfunction

		function int pixels_left();
			longint dy;
			dy = (ay > by) ? ay - by : by - ay;
			case (phase)
			WALK_X: return int'(((ax > bx) ? ax : bx) - walk + dy);
			WALK_Y: return int'(((ay > by) ? ay : by) - walk);
			default: return 0;
			endcase
		endfunction

		function void note_word(input logic c, input logic [GRID_BITS-1:0] fx,
				input logic [GRID_BITS-1:0] fy, input logic [GRID_BITS-1:0] tx,
				input logic [GRID_BITS-1:0] ty);
			longint a_m, a_o, b_m, b_o, lo_m, lo_o, hi_m, hi_o, other;
			bit     on_y;
			pixel_t p;
			if (c == CMD_START) begin
				starts++;
				ax = scaled(fx, org_x);
				ay = scaled(fy, org_y);
				bx = scaled(tx, org_x);
				by = scaled(ty, org_y);
				if (ax == bx) begin
					enter_y_walk();
				end else begin
					walk = (ax < bx) ? ax : bx;
					phase = WALK_X;
				end
				return;
			end
			ticks++;
			if (phase == WALK_IDLE) begin
				idle_ticks++;
				return;
			end
			// m walks, o is interpolated
			on_y = (phase == WALK_Y);
			a_m = on_y ? ay : ax;
			a_o = on_y ? ax : ay;
			b_m = on_y ? by : bx;
			b_o = on_y ? bx : by;
			if (a_m < b_m) begin
				lo_m = a_m; lo_o = a_o; hi_m = b_m; hi_o = b_o;
			end else begin
				lo_m = b_m; lo_o = b_o; hi_m = a_m; hi_o = a_o;
			end
			if (hi_m == lo_m) begin
				phase = WALK_IDLE;
				return;
			end
			other = (walk - lo_m) * (hi_o - lo_o) / (hi_m - lo_m) + lo_o;
			p.x = OUT_W'(on_y ? other : walk);
			p.y = OUT_W'(on_y ? walk : other);
			walk = walk + 1;
			if (walk >= hi_m) begin
				if (on_y)
					phase = WALK_IDLE;
				else
					enter_y_walk();
			end
			p.last = (phase == WALK_IDLE);
			expected_pixels.push_back(p);
		endfunction

		task report(input string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_pixel(input logic [OUT_W-1:0] x, input logic [OUT_W-1:0] y,
				input logic last);
			pixel_t e;
			if (expected_pixels.size() == 0) begin
				report($sformatf("pixel x=%0d y=%0d last=%0b with none expected", x, y, last));
				return;
			end
			e = expected_pixels.pop_front();
			pixels_seen++;
			if (e.last)
				last_seen++;
			if (x !== e.x)
				report($sformatf("pixel_x %0d, expected %0d", x, e.x));
			if (y !== e.y)
				report($sformatf("pixel_y %0d, expected %0d", y, e.y));
			if (last !== e.last)
				report($sformatf("last_pixel %0b, expected %0b at x=%0d y=%0d",
					last, e.last, e.x, e.y));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  cmd;
	logic [GRID_BITS-1:0]  from_x;
	logic [GRID_BITS-1:0]  from_y;
	logic [GRID_BITS-1:0]  to_x;
	logic [GRID_BITS-1:0]  to_y;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_W-1:0]      pixel_x;
	logic [OUT_W-1:0]      pixel_y;
	logic                  last_pixel;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pixel_scoreboard sb = new();
	int              hold_req = 0;
	int              hold_ack = 0;
	int              settings_done = 0;
	bit              tx_calm = 0;

	scaled_segment_rasterizer u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#TIMEOUT_NS;
		$display("scaled_segment_rasterizer test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(pixel_x, pixel_y, last_pixel);
	end

	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [GRID_BITS-1:0] pick_coord();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return GRID_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [GRID_BITS-1:0] near(input logic [GRID_BITS-1:0] c,
			input int reach);
		int v;
		v = int'(c) + $urandom_range(0, 2 * reach) - reach;
		if (v < 0)
			v = 0;
		if (v > (1 << GRID_BITS) - 1)
			v = (1 << GRID_BITS) - 1;
		return GRID_BITS'(v);
	endfunction

	// receiver: random stalls, calm stretches, and one long hold on request
	initial begin
		int rx_gap;
		bit rx_calm;
		rx_gap = 0;
		rx_calm = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 299) == 0)
				rx_calm = !rx_calm;
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
			end else if (rx_gap > 0) begin
				out_ready <= 1'b0;
				rx_gap--;
			end else begin
				out_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					rx_gap = draw_gap();
			end
		end
	end

	task automatic drive_word(input logic c, input logic [GRID_BITS-1:0] fx,
			input logic [GRID_BITS-1:0] fy, input logic [GRID_BITS-1:0] tx,
			input logic [GRID_BITS-1:0] ty);
		int gap;
		in_valid <= 1'b1;
		cmd      <= c;
		from_x   <= fx;
		from_y   <= fy;
		to_x     <= tx;
		to_y     <= ty;
		do @(posedge clk); while (!in_ready);
		sb.note_word(c, fx, fy, tx, ty);
		if ($urandom_range(0, 99) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// tick fields carry random junk; the block must ignore it
	task automatic tick_n(input int n);
		repeat (n)
			drive_word(CMD_TICK, GRID_BITS'($urandom), GRID_BITS'($urandom),
				GRID_BITS'($urandom), GRID_BITS'($urandom));
	endtask

	// hold the input until every pixel is out and the engine has settled
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int step, input int xo, input int yo);
		wait_quiet();
		write_reg(REG_STEP, CFG_DATA_W'(step));
		write_reg(REG_XORG, CFG_DATA_W'(xo));
		write_reg(REG_YORG, CFG_DATA_W'(yo));
		settings_done++;
	endtask

	// mostly well-formed segments, short ones walked to the end and long ones cut short, some noise words
	task automatic run_segments(input int n_words);
		int                   sent, reach, left, n;
		logic [GRID_BITS-1:0] fx, fy;
		sent = 0;
		while (sent < n_words) begin
			if ($urandom_range(0, 99) < 12) begin
				drive_word(($urandom_range(0, 1) == 1) ? CMD_TICK : CMD_START,
					GRID_BITS'($urandom), GRID_BITS'($urandom),
					GRID_BITS'($urandom), GRID_BITS'($urandom));
				sent++;
			end else begin
				reach = (sb.step <= 4) ? 4 : 1;
				fx = pick_coord();
				fy = pick_coord();
				drive_word(CMD_START, fx, fy, near(fx, reach), near(fy, reach));
				left = sb.pixels_left();
				n = (left <= 40) ? left + $urandom_range(0, 2) : $urandom_range(1, 25);
				tick_n(n);
				sent += n + 1;
				if ($urandom_range(0, 19) == 0)
					wait_quiet();
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_START;
		from_x    <= '0;
		from_y    <= '0;
		to_x      <= '0;
		to_y      <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_STEP;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset scale: idle tick, empty segment, single passes, both passes
		drive_word(CMD_TICK, '1, '1, '1, '1);
		drive_word(CMD_START, 8'd4, 8'd4, 8'd4, 8'd4);
		drive_word(CMD_TICK, '0, '0, '0, '0);
		drive_word(CMD_START, 8'd3, 8'd7, 8'd0, 8'd7);
		tick_n(3);
		drive_word(CMD_START, 8'd9, 8'd2, 8'd9, 8'd6);
		tick_n(4);
		drive_word(CMD_START, 8'd5, 8'd1, 8'd2, 8'd4);
		tick_n(6);
		drive_word(CMD_START, 8'd0, 8'd255, 8'd255, 8'd0);
		tick_n(2);
		// abort the long walk with an empty segment
		drive_word(CMD_START, 8'd255, 8'd255, 8'd255, 8'd255);
		drive_word(CMD_TICK, '1, '1, '1, '1);

		// stall the receiver while ticks keep coming so the input backs up
		wait_quiet();
		hold_req++;
		drive_word(CMD_START, 8'd0, 8'd0, 8'd200, 8'd100);
		tick_n(12);

		apply_setting(0, 2047, 2047);
		run_segments(40);
		apply_setting(255, 0, 0);
		run_segments(150);
		apply_setting(255, 2047, 2047);
		run_segments(150);
		apply_setting(1, 0, 0);
		run_segments(150);
		apply_setting(2, 1024, 3);
		run_segments(150);
		repeat (3) begin
			apply_setting($urandom_range(1, 8), $urandom_range(0, 2047), $urandom_range(0, 2047));
			run_segments(150);
		end
		wait_quiet();

		$display("Drove %0d words: %0d segment starts, %0d ticks (%0d on an idle walker).",
			sb.starts + sb.ticks, sb.starts, sb.ticks, sb.idle_ticks);
		$display("Checked %0d pixels, %0d closing a segment, over %0d register settings.",
			sb.pixels_seen, sb.last_seen, settings_done);
		if (sb.errors == 0)
			$display("scaled_segment_rasterizer test passed");
		else
			$display("scaled_segment_rasterizer test failed");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/ssr_pkg.sv
sv/ssr_front.sv
sv/ssr_queue.sv
sv/ssr_back.sv
sv/scaled_segment_rasterizer.sv
sv/ssr_checker.sv
test/scaled_segment_rasterizer_tb.sv
